FILE: design/obst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obst_pkg
// Shared constants and types for the optimal BST builder.
// ----------------------------------------------------------------------------
package obst_pkg;

  localparam int DEF_MAX_KEYS    = 64;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int DEF_COST_BITS   = 32;

  localparam int KEY_COUNT_BITS  = 7;
  localparam int ROOT_KEY_BITS   = 7;
  localparam int TOTAL_BITS      = 32;

  // status of the build engine, seen by the loader and the job queue
  typedef struct packed {
    logic busy;   // a build or walk is running
    logic take;   // engine takes the queued job this cycle
  } back_stat_t;

endpackage

FILE: design/obst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obst_front
// Loader: key count register, item counting and prefix sum memories.
// ----------------------------------------------------------------------------
module obst_front #(
  parameter int MAX_KEYS    = obst_pkg::DEF_MAX_KEYS,
  parameter int WEIGHT_BITS = obst_pkg::DEF_WEIGHT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [obst_pkg::KEY_COUNT_BITS-1:0] cfg_wdata,
  input  logic                               load_valid,
  output logic                               load_stall,
  input  logic [WEIGHT_BITS-1:0]             key_weight,
  input  logic [WEIGHT_BITS-1:0]             gap_weight,
  input  logic                               hold,
  output logic                               job_push,
  output logic [$clog2(MAX_KEYS+2)-1:0]      job_n,
  input  logic [$clog2(MAX_KEYS+2)-1:0]      key_addr_a,
  input  logic [$clog2(MAX_KEYS+2)-1:0]      key_addr_b,
  input  logic [$clog2(MAX_KEYS+2)-1:0]      gap_addr_a,
  input  logic [$clog2(MAX_KEYS+2)-1:0]      gap_addr_b,
  output logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] key_sum_a,
  output logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] key_sum_b,
  output logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] gap_sum_a,
  output logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] gap_sum_b
);

  localparam int IW  = $clog2(MAX_KEYS + 2);
  localparam int PW  = WEIGHT_BITS + $clog2(MAX_KEYS + 2);
  localparam int KAW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int GAW = $clog2(MAX_KEYS + 1);

  // entry j holds the prefix sum through item j (prefix index j+1)
  logic [PW-1:0] key_mem [MAX_KEYS];
  logic [PW-1:0] gap_mem [MAX_KEYS+1];

  logic [obst_pkg::KEY_COUNT_BITS-1:0] key_count;
  logic [IW-1:0] loaded;
  logic [PW-1:0] key_run;
  logic [PW-1:0] gap_run;
  logic [IW-1:0] n_eff;
  logic [IW-1:0] idx;
  logic [PW-1:0] key_base;
  logic [PW-1:0] gap_base;
  logic [PW-1:0] key_new;
  logic [PW-1:0] gap_new;
  logic          accept;
  logic          final_item;
  logic [PW-1:0] key_rd_a, key_rd_b, gap_rd_a, gap_rd_b;
  logic          key_z_a, gap_z_a;

  always_comb begin
    if (key_count == '0) begin
      n_eff = IW'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n_eff = IW'(MAX_KEYS);
    end else begin
      n_eff = IW'(key_count);
    end
  end

  assign idx        = (loaded > n_eff) ? '0 : loaded;
  assign key_base   = (idx == '0) ? '0 : key_run;
  assign gap_base   = (idx == '0) ? '0 : gap_run;
  assign key_new    = key_base + ((idx < n_eff) ? PW'(key_weight) : '0);
  assign gap_new    = gap_base + PW'(gap_weight);
  assign load_stall = hold;
  assign accept     = load_valid && !load_stall;
  assign final_item = (idx == n_eff);
  assign job_push   = accept && final_item;
  assign job_n      = n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= obst_pkg::KEY_COUNT_BITS'(1);
      loaded    <= '0;
    end else if (cfg_we) begin
      key_count <= cfg_wdata;
      loaded    <= '0;
    end else if (accept) begin
      loaded <= final_item ? '0 : idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_run <= key_new;
      gap_run <= gap_new;
      if (idx < n_eff) begin
        key_mem[idx[KAW-1:0]] <= key_new;
      end
      gap_mem[idx[GAW-1:0]] <= gap_new;
    end
  end

  // prefix index 0 reads as zero; only the a-ports ever ask for it
  always_ff @(posedge clk) begin
    key_rd_a <= key_mem[KAW'(key_addr_a - IW'(1))];
    key_rd_b <= key_mem[KAW'(key_addr_b - IW'(1))];
    gap_rd_a <= gap_mem[GAW'(gap_addr_a - IW'(1))];
    gap_rd_b <= gap_mem[GAW'(gap_addr_b - IW'(1))];
    key_z_a  <= (key_addr_a == '0);
    gap_z_a  <= (gap_addr_a == '0);
  end

  assign key_sum_a = key_z_a ? '0 : key_rd_a;
  assign key_sum_b = key_rd_b;
  assign gap_sum_a = gap_z_a ? '0 : gap_rd_a;
  assign gap_sum_b = gap_rd_b;

endmodule

FILE: design/obst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obst_queue
// Two-entry job queue between loader and build engine.
// ----------------------------------------------------------------------------
module obst_queue #(
  parameter int WIDTH = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slot0, slot1;
  logic [1:0]       count;

  assign empty = (count == 2'd0);
  assign head  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push && (count != 2'd2), pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !empty) begin
      slot0 <= (count == 2'd2) ? slot1 : push_data;
      if (push) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

FILE: design/obst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obst_back
// Build engine: Knuth-Yao table fill, then stack-driven preorder walk.
// ----------------------------------------------------------------------------
module obst_back #(
  parameter int MAX_KEYS    = obst_pkg::DEF_MAX_KEYS,
  parameter int WEIGHT_BITS = obst_pkg::DEF_WEIGHT_BITS,
  parameter int COST_BITS   = obst_pkg::DEF_COST_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   job_ready,
  input  logic [$clog2(MAX_KEYS+2)-1:0]          job_n,
  output obst_pkg::back_stat_t                   stat,
  output logic [$clog2(MAX_KEYS+2)-1:0]          key_addr_a,
  output logic [$clog2(MAX_KEYS+2)-1:0]          key_addr_b,
  output logic [$clog2(MAX_KEYS+2)-1:0]          gap_addr_a,
  output logic [$clog2(MAX_KEYS+2)-1:0]          gap_addr_b,
  input  logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] key_sum_a,
  input  logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] key_sum_b,
  input  logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] gap_sum_a,
  input  logic [WEIGHT_BITS+$clog2(MAX_KEYS+2)-1:0] gap_sum_b,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [obst_pkg::ROOT_KEY_BITS-1:0]     root_key,
  output logic [obst_pkg::TOTAL_BITS-1:0]        total_cost,
  output logic                                   last_out
);

  localparam int IW    = $clog2(MAX_KEYS + 2);
  localparam int ROW   = MAX_KEYS + 1;
  localparam int DEPTH = MAX_KEYS * ROW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int PW    = WEIGHT_BITS + $clog2(MAX_KEYS + 2);
  localparam int SPW   = $clog2(MAX_KEYS + 1);
  localparam int SAW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int XW    = (PW + 1 > COST_BITS + 1) ? PW + 1 : COST_BITS + 1;
  localparam int TW    = (COST_BITS > obst_pkg::TOTAL_BITS) ? COST_BITS
                                                            : obst_pkg::TOTAL_BITS;
  localparam logic [COST_BITS-1:0] CMAX = {COST_BITS{1'b1}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DIF   = 4'd2;
  localparam logic [3:0] S_W     = 4'd3;
  localparam logic [3:0] S_KRD   = 4'd4;
  localparam logic [3:0] S_KAB   = 4'd5;
  localparam logic [3:0] S_KEV   = 4'd6;
  localparam logic [3:0] S_KWR   = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_TOT   = 4'd9;
  localparam logic [3:0] S_TOTD  = 4'd10;
  localparam logic [3:0] S_ROOT  = 4'd11;
  localparam logic [3:0] S_ROOTD = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;
  localparam logic [3:0] S_PUSH1 = 4'd14;
  localparam logic [3:0] S_PUSH2 = 4'd15;

  function automatic logic [AW-1:0] cidx(input logic [IW-1:0] a, input logic [IW-1:0] b);
    return AW'(a) * AW'(ROW) + AW'(b);
  endfunction

  function automatic logic [COST_BITS-1:0] sat(input logic [XW-1:0] v);
    return (v >= XW'(CMAX)) ? CMAX : v[COST_BITS-1:0];
  endfunction

  logic [COST_BITS-1:0] cost_mem  [DEPTH];
  logic [RW-1:0]        root_mem  [DEPTH];
  logic [2*IW-1:0]      stack_mem [MAX_KEYS];

  logic [3:0]  st;
  logic        popping;   // walk is fetching the next span from the stack
  logic [IW-1:0] n, l, r, k, lo, hi, kw;
  logic        diag;
  logic [PW-1:0]        kd, gd;
  logic [COST_BITS-1:0] wreg, ab, best;
  logic [RW-1:0]        broot;
  logic [obst_pkg::TOTAL_BITS-1:0] total;
  logic [SPW-1:0]       sp, cnt;
  logic                 lastreg;

  logic [AW-1:0]        cost_ra, cost_rb, root_ra, root_rb, tab_wa;
  logic [COST_BITS-1:0] cost_da, cost_db, cost_wd;
  logic [RW-1:0]        root_da, root_db, root_wd;
  logic                 tab_we;
  logic [2*IW-1:0]      stack_d;
  logic                 stack_we;
  logic [2*IW-1:0]      stack_wd;
  logic [COST_BITS-1:0] w_now, c_now, ab_now;
  logic [IW-1:0]        lo_now, hi_now, kroot;
  logic                 p1, p2, last_now, slot_free;
  logic [SPW:0]         sp1;
  logic [TW-1:0]        tot_x;

  assign stat.busy = (st != S_IDLE) || popping;
  assign stat.take = (st == S_IDLE) && !popping && job_ready;

  // prefix sum reads: key sums at l and r, gap sums at l and r+1
  assign key_addr_a = l;
  assign key_addr_b = r;
  assign gap_addr_a = l;
  assign gap_addr_b = r + IW'(1);

  assign cost_ra = (st == S_TOT) ? cidx('0, n) : cidx(l, k);
  assign cost_rb = cidx(k + IW'(1), r);
  assign root_ra = (st == S_ROOT) ? cidx(l, r) : cidx(l, r - IW'(1));
  assign root_rb = cidx(l + IW'(1), r);
  assign tab_wa  = cidx(l, r);

  assign w_now  = sat(XW'(kd) + XW'(gd));
  assign ab_now = sat(XW'((k > l) ? cost_da : '0) + XW'((k + IW'(1) < r) ? cost_db : '0));
  assign c_now  = sat(XW'(ab) + XW'(wreg));
  assign lo_now = (IW'(root_da) < l) ? l : IW'(root_da);
  assign hi_now = (IW'(root_db) > r - IW'(1)) ? r - IW'(1) : IW'(root_db);

  always_comb begin
    kroot = (r - l == IW'(1)) ? l : IW'(root_da);
    if (kroot < l) begin
      kroot = l;
    end
    if (kroot > r - IW'(1)) begin
      kroot = r - IW'(1);
    end
  end

  assign p1       = (kw + IW'(1) < r) && (32'(sp) < MAX_KEYS);
  assign sp1      = (SPW+1)'(sp) + (SPW+1)'(p1);
  assign p2       = (kw > l) && (32'(sp1) < MAX_KEYS);
  assign last_now = ((sp1 + (SPW+1)'(p2)) == '0) || (32'(cnt) + 1 == MAX_KEYS);
  assign slot_free = !result_valid || !result_stall;
  assign tot_x    = TW'(cost_da);

  always_comb begin
    tab_we  = 1'b0;
    cost_wd = best;
    root_wd = broot;
    if (st == S_W) begin
      if (diag) begin
        tab_we  = 1'b1;
        cost_wd = w_now;
        root_wd = RW'(l);
      end else if (lo > hi) begin
        tab_we  = 1'b1;
        cost_wd = CMAX;
        root_wd = '0;
      end
    end else if (st == S_KWR) begin
      tab_we = 1'b1;
    end
  end

  always_comb begin
    stack_we = 1'b0;
    stack_wd = {kw + IW'(1), r};
    if (st == S_PUSH1 && (kw + IW'(1) < r) && (32'(sp) < MAX_KEYS)) begin
      stack_we = 1'b1;
    end else if (st == S_PUSH2 && (kw > l) && (32'(sp) < MAX_KEYS)) begin
      stack_we = 1'b1;
      stack_wd = {l, kw};
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      cost_mem[tab_wa] <= cost_wd;
      root_mem[tab_wa] <= root_wd;
    end
    cost_da <= cost_mem[cost_ra];
    cost_db <= cost_mem[cost_rb];
    root_da <= root_mem[root_ra];
    root_db <= root_mem[root_rb];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[SAW'(sp)] <= stack_wd;
    end
    stack_d <= stack_mem[SAW'(sp - SPW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      popping      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (st == S_EMIT && !popping && slot_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (popping) begin
        // pop finishes: stack data is out of the memory
        popping <= 1'b0;
        l       <= stack_d[2*IW-1:IW];
        r       <= stack_d[IW-1:0];
        st      <= S_ROOT;
      end else begin
        unique case (st)
          S_IDLE: begin
            if (job_ready) begin
              n    <= job_n;
              l    <= '0;
              r    <= IW'(1);
              diag <= 1'b1;
              st   <= S_RD;
            end
          end
          S_RD: st <= S_DIF;
          S_DIF: begin
            kd <= key_sum_b - key_sum_a;
            gd <= gap_sum_b - gap_sum_a;
            lo <= lo_now;
            hi <= hi_now;
            st <= S_W;
          end
          S_W: begin
            wreg  <= w_now;
            best  <= CMAX;
            broot <= '0;
            k     <= lo;
            st    <= (diag || lo > hi) ? S_NEXT : S_KRD;
          end
          S_KRD: st <= S_KAB;
          S_KAB: begin
            ab <= ab_now;
            st <= S_KEV;
          end
          S_KEV: begin
            if (best > c_now) begin
              best  <= c_now;
              broot <= RW'(k);
            end
            if (k == hi) begin
              st <= S_KWR;
            end else begin
              k  <= k + IW'(1);
              st <= S_KRD;
            end
          end
          S_KWR: st <= S_NEXT;
          S_NEXT: begin
            if (diag) begin
              if (l + IW'(1) < n) begin
                l  <= l + IW'(1);
                r  <= l + IW'(2);
                st <= S_RD;
              end else if (n == IW'(1)) begin
                st <= S_TOT;
              end else begin
                diag <= 1'b0;
                l    <= n - IW'(2);
                r    <= n;
                st   <= S_RD;
              end
            end else if (r < n) begin
              r  <= r + IW'(1);
              st <= S_RD;
            end else if (l == '0) begin
              st <= S_TOT;
            end else begin
              l  <= l - IW'(1);
              r  <= l + IW'(1);
              st <= S_RD;
            end
          end
          S_TOT: st <= S_TOTD;
          S_TOTD: begin
            total <= (tot_x > TW'({obst_pkg::TOTAL_BITS{1'b1}})) ?
                     {obst_pkg::TOTAL_BITS{1'b1}} : tot_x[obst_pkg::TOTAL_BITS-1:0];
            l   <= '0;
            r   <= n;
            sp  <= '0;
            cnt <= '0;
            st  <= S_ROOT;
          end
          S_ROOT: st <= S_ROOTD;
          S_ROOTD: begin
            kw <= kroot;
            st <= S_EMIT;
          end
          S_EMIT: begin
            if (slot_free) begin
              root_key     <= obst_pkg::ROOT_KEY_BITS'(kw + IW'(1));
              total_cost   <= total;
              last_out     <= last_now;
              lastreg      <= last_now;
              cnt          <= cnt + SPW'(1);
              st           <= S_PUSH1;
            end
          end
          S_PUSH1: begin
            if (stack_we) begin
              sp <= sp + SPW'(1);
            end
            st <= S_PUSH2;
          end
          S_PUSH2: begin
            if (lastreg) begin
              st <= S_IDLE;
            end else if (stack_we) begin
              // left child goes next: its push and pop cancel out
              r  <= kw;
              st <= S_ROOT;
            end else begin
              // pop: address sp-1 is read now, data arrives next cycle
              popping <= 1'b1;
              sp      <= sp - SPW'(1);
              st      <= S_ROOT;
            end
          end
          default: st <= S_IDLE;
        endcase
      end
    end
  end

endmodule

FILE: design/optimal_bst_knuth_dp.sv
`timescale 1ns / 1ps
// The final word of a tree starts the build; the first result follows the table fill.
// Each result word of the preorder walk takes a root read, decode, emit (held while result_stall
//   blocks the output) and two pushes, plus a stack pop when the next span comes off the stack.
// Load words enter one per cycle while load_stall is low; the loader holds load_stall
//   high while a build is queued or running.
// Reset (rst, synchronous, active high): key_count = 1, load count and all control cleared;
//   tables, prefix sums and walk stack are left as they are and rewritten before use.
// ----------------------------------------------------------------------------
// optimal_bst_knuth_dp
// Optimal binary search tree builder with Knuth-Yao narrowed root search.
// ----------------------------------------------------------------------------
//
// Structure:
//   obst_front : takes load words, keeps key_count, writes prefix sums. On
//                the final word of a tree it queues a build job (key count).
//   obst_queue : two-entry job queue; the front stalls while a job waits in it.
//   obst_back  : fills the interval cost / best root tables over half-open
//                intervals, diagonal first, then row by row with l falling
//                and r rising, one candidate root at a time, then walks the
//                tree in preorder with an explicit stack and sends one result
//                word per key through a single output register.
//
// The prefix sum memories live in the front; the engine drives their read
// addresses. The front does not take words while a job is queued or the
// engine is busy, so the sums never change under a running build.
module optimal_bst_knuth_dp #(
  parameter int MAX_KEYS    = obst_pkg::DEF_MAX_KEYS,
  parameter int WEIGHT_BITS = obst_pkg::DEF_WEIGHT_BITS,
  parameter int COST_BITS   = obst_pkg::DEF_COST_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [obst_pkg::KEY_COUNT_BITS-1:0] cfg_wdata,
  input  logic                                load_valid,
  output logic                                load_stall,
  input  logic [WEIGHT_BITS-1:0]              key_weight,
  input  logic [WEIGHT_BITS-1:0]              gap_weight,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [obst_pkg::ROOT_KEY_BITS-1:0]  root_key,
  output logic [obst_pkg::TOTAL_BITS-1:0]     total_cost,
  output logic                                last_out
);

  localparam int IW = $clog2(MAX_KEYS + 2);
  localparam int PW = WEIGHT_BITS + $clog2(MAX_KEYS + 2);

  obst_pkg::back_stat_t stat;
  logic          job_push;
  logic [IW-1:0] job_n;
  logic          q_empty;
  logic [IW-1:0] q_head;
  logic          hold;
  logic [IW-1:0] key_addr_a, key_addr_b, gap_addr_a, gap_addr_b;
  logic [PW-1:0] key_sum_a, key_sum_b, gap_sum_a, gap_sum_b;

  // loader waits while any build is pending or running
  assign hold = !q_empty || stat.busy;

  obst_front #(
    .MAX_KEYS    (MAX_KEYS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .load_valid (load_valid),
    .load_stall (load_stall),
    .key_weight (key_weight),
    .gap_weight (gap_weight),
    .hold       (hold),
    .job_push   (job_push),
    .job_n      (job_n),
    .key_addr_a (key_addr_a),
    .key_addr_b (key_addr_b),
    .gap_addr_a (gap_addr_a),
    .gap_addr_b (gap_addr_b),
    .key_sum_a  (key_sum_a),
    .key_sum_b  (key_sum_b),
    .gap_sum_a  (gap_sum_a),
    .gap_sum_b  (gap_sum_b)
  );

  obst_queue #(
    .WIDTH (IW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_n),
    .pop       (stat.take),
    .empty     (q_empty),
    .head      (q_head)
  );

  obst_back #(
    .MAX_KEYS    (MAX_KEYS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .COST_BITS   (COST_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_ready    (!q_empty),
    .job_n        (q_head),
    .stat         (stat),
    .key_addr_a   (key_addr_a),
    .key_addr_b   (key_addr_b),
    .gap_addr_a   (gap_addr_a),
    .gap_addr_b   (gap_addr_b),
    .key_sum_a    (key_sum_a),
    .key_sum_b    (key_sum_b),
    .gap_sum_a    (gap_sum_a),
    .gap_sum_b    (gap_sum_b),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .root_key     (root_key),
    .total_cost   (total_cost),
    .last_out     (last_out)
  );

  // a queued job blocks the loader on the very next cycle
  a_job_blocks_load: assert property (@(posedge clk) disable iff (rst)
    job_push |=> load_stall)
    else $error("loader open after job queued");

  // only one job can ever be waiting
  a_queue_single: assert property (@(posedge clk) disable iff (rst)
    job_push |-> q_empty)
    else $error("job queued while another waits");

  // results only come out of a running engine
  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stat.busy))
    else $error("result word without build");

endmodule
